/* rtl/polyphonic_sawtooth_phase_mixer_unit_macros.svh */
// Assertion macros shared by the checker of the sawtooth phase mixer.
`ifndef POLYPHONIC_SAWTOOTH_PHASE_MIXER_UNIT_MACROS_SVH
`define POLYPHONIC_SAWTOOTH_PHASE_MIXER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSPM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pspm_pkg.sv */
// Package with types, constants and the note step table of the sawtooth phase mixer.
package pspm_pkg;

   localparam int LOCAL_KEYS_DEFAULT  = 12;
   localparam int VOICE_COUNT_DEFAULT = 24;

   localparam int PHASE_W   = 32;
   localparam int OCTAVE_W  = 4;
   localparam int VOLUME_W  = 4;
   localparam int NOTE_W    = 8;
   localparam int SAMPLE_W  = 13;
   localparam int KEY_IDX_W = 5;
   localparam int REMOTE_W  = 9;

   localparam logic [OCTAVE_W-1:0] OCTAVE_NOMINAL = 4'd4;
   localparam logic [VOLUME_W-1:0] VOLUME_FULL    = 4'd8;
   localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET  = 13'd128;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

   function automatic logic [PHASE_W-1:0] note_step(input logic [KEY_IDX_W-1:0] key);
      logic [PHASE_W-1:0] step;
      case (key)
         5'd0:    step = 32'd50953930;
         5'd1:    step = 32'd54077542;
         5'd2:    step = 32'd57201155;
         5'd3:    step = 32'd60715219;
         5'd4:    step = 32'd64229283;
         5'd5:    step = 32'd68133799;
         5'd6:    step = 32'd72038315;
         5'd7:    step = 32'd76528508;
         5'd8:    step = 32'd81018701;
         5'd9:    step = 32'd85899345;
         5'd10:   step = 32'd90975216;
         5'd11:   step = 32'd96246312;
         default: step = '0;
      endcase
      return step;
   endfunction

endpackage

/* rtl/pspm_ctrl.sv */
// Controller state machine that sequences one sample tick over all voices.
module pspm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pspm_pkg::status_type status,
   output pspm_pkg::cmd_type    cmd
);

   pspm_pkg::state_type state_ff;
   pspm_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pspm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = pspm_pkg::ST_RUN;
            end
         end
         pspm_pkg::ST_RUN: begin
            if (status.last) begin
               state_in = pspm_pkg::ST_FINISH;
            end
         end
         pspm_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = req_valid ? pspm_pkg::ST_RUN : pspm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pspm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         pspm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         pspm_pkg::ST_RUN: begin
            cmd.step = 1'b1;
         end
         pspm_pkg::ST_FINISH: begin
            req_ready = out_free;
            cmd.load  = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.start = req_valid && req_ready;
   end

   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pspm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/pspm_datapath.sv */
// Datapath with the phase accumulators, the voice walker and the sample sum.
module pspm_datapath #(
   parameter int LOCAL_KEYS  = pspm_pkg::LOCAL_KEYS_DEFAULT,
   parameter int VOICE_COUNT = pspm_pkg::VOICE_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pspm_pkg::cmd_type                   cmd,
   output pspm_pkg::status_type                status,
   input  logic [LOCAL_KEYS-1:0]               req_key_up_mask,
   input  logic [pspm_pkg::OCTAVE_W-1:0]       req_octave,
   input  logic [pspm_pkg::VOLUME_W-1:0]       req_volume,
   input  logic [pspm_pkg::NOTE_W-1:0]         req_remote_note,
   input  logic signed [pspm_pkg::PHASE_W-1:0] req_remote_step,
   output logic signed [pspm_pkg::SAMPLE_W-1:0] rsp_sample_out
);

   localparam int CNT_W = $clog2(VOICE_COUNT);

   logic [LOCAL_KEYS-1:0]                mask_ff;
   logic [pspm_pkg::OCTAVE_W-1:0]        octave_ff;
   logic [pspm_pkg::VOLUME_W-1:0]        shift_ff;
   logic [pspm_pkg::VOLUME_W-1:0]        shift_in;
   logic [pspm_pkg::REMOTE_W-1:0]        remote_idx_ff;
   logic [pspm_pkg::PHASE_W-1:0]         remote_step_ff;
   logic [CNT_W-1:0]                     cnt_ff;
   logic [CNT_W-1:0]                     cnt_in;
   logic [pspm_pkg::PHASE_W-1:0]         acc_ff [VOICE_COUNT];
   logic [pspm_pkg::PHASE_W-1:0]         acc_in;
   logic signed [pspm_pkg::SAMPLE_W-1:0] sum_ff;
   logic signed [pspm_pkg::SAMPLE_W-1:0] sum_in;
   logic signed [pspm_pkg::SAMPLE_W-1:0] sample_ff;
   logic                                 pressed;
   logic                                 remote_hit;
   logic [pspm_pkg::PHASE_W-1:0]         base_step;
   logic [pspm_pkg::PHASE_W-1:0]         key_step;
   logic [pspm_pkg::PHASE_W-1:0]         addend;
   logic signed [7:0]                    voice_raw;
   logic signed [7:0]                    voice_scaled;

   always_comb begin
      if (req_volume > pspm_pkg::VOLUME_FULL) begin
         shift_in = '0;
      end else begin
         shift_in = pspm_pkg::VOLUME_FULL - req_volume;
      end
   end

   always_comb begin
      pressed = 1'b0;
      for (int k = 0; k < LOCAL_KEYS; k++) begin
         if (int'(cnt_ff) == k) begin
            pressed = !mask_ff[k];
         end
      end
   end

   assign base_step = pspm_pkg::note_step(pspm_pkg::KEY_IDX_W'(cnt_ff));

   always_comb begin
      if (octave_ff > pspm_pkg::OCTAVE_NOMINAL) begin
         key_step = base_step << (octave_ff - pspm_pkg::OCTAVE_NOMINAL);
      end else begin
         key_step = base_step >> (pspm_pkg::OCTAVE_NOMINAL - octave_ff);
      end
   end

   // Local keys sit below the remote voice, so at most one addend applies.
   assign remote_hit = (pspm_pkg::REMOTE_W'(cnt_ff) == remote_idx_ff);

   always_comb begin
      if (pressed) begin
         addend = key_step;
      end else if (remote_hit) begin
         addend = remote_step_ff;
      end else begin
         addend = '0;
      end
   end

   assign acc_in       = acc_ff[cnt_ff] + addend;
   assign voice_raw    = {!acc_in[pspm_pkg::PHASE_W-1], acc_in[pspm_pkg::PHASE_W-2 -: 7]};
   assign voice_scaled = voice_raw >>> shift_ff;

   always_comb begin
      if (cmd.start) begin
         sum_in = '0;
      end else if (cmd.step) begin
         sum_in = sum_ff + pspm_pkg::SAMPLE_W'(voice_scaled);
      end else begin
         sum_in = sum_ff;
      end
   end

   always_comb begin
      if (cmd.start) begin
         cnt_in = '0;
      end else if (cmd.step) begin
         cnt_in = status.last ? '0 : cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   assign status.last = (cnt_ff == CNT_W'(VOICE_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         for (int v = 0; v < VOICE_COUNT; v++) begin
            acc_ff[v] <= '0;
         end
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.step) begin
            acc_ff[cnt_ff] <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (cmd.start) begin
         mask_ff        <= req_key_up_mask;
         octave_ff      <= req_octave;
         shift_ff       <= shift_in;
         remote_idx_ff  <= pspm_pkg::REMOTE_W'(req_remote_note)
                           + pspm_pkg::REMOTE_W'(LOCAL_KEYS);
         remote_step_ff <= req_remote_step;
      end
      if (cmd.load) begin
         sample_ff <= sum_ff + pspm_pkg::SAMPLE_OFFSET;
      end
   end

   assign rsp_sample_out = sample_ff;

endmodule

/* rtl/polyphonic_sawtooth_phase_mixer_unit.sv */
// Top level of the polyphonic sawtooth phase mixer.
// Each transfer on the req_ channel is one audio sample tick: a key mask,
// octave, volume and one remote note with its phase step. Each tick
// produces exactly one transfer on the rsp_ channel carrying the summed
// sawtooth sample of all voices, offset by 128 and wrapped to 13 bits.
// The datapath visits one phase accumulator per cycle, so a tick walks
// all VOICE_COUNT voices and then loads the result register. No new
// tick is taken while the voice walk is in progress.
// req_ready is high while the block is idle and in the cycle the result
// register is loaded, so the next tick starts while the previous result
// still waits on the rsp_ channel. If the receiver stalls, the finished
// sum is held until the result register is free, and no new tick is taken.
// Synchronous reset clears every phase accumulator to zero and drops
// rsp_valid.
module polyphonic_sawtooth_phase_mixer_unit #(
   parameter int LOCAL_KEYS  = pspm_pkg::LOCAL_KEYS_DEFAULT,
   parameter int VOICE_COUNT = pspm_pkg::VOICE_COUNT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [LOCAL_KEYS-1:0]                req_key_up_mask,
   input  logic [pspm_pkg::OCTAVE_W-1:0]        req_octave,
   input  logic [pspm_pkg::VOLUME_W-1:0]        req_volume,
   input  logic [pspm_pkg::NOTE_W-1:0]          req_remote_note,
   input  logic signed [pspm_pkg::PHASE_W-1:0]  req_remote_step,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pspm_pkg::SAMPLE_W-1:0] rsp_sample_out
);

   pspm_pkg::cmd_type    cmd;
   pspm_pkg::status_type status;

   pspm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pspm_datapath #(
      .LOCAL_KEYS  (LOCAL_KEYS),
      .VOICE_COUNT (VOICE_COUNT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_key_up_mask (req_key_up_mask),
      .req_octave      (req_octave),
      .req_volume      (req_volume),
      .req_remote_note (req_remote_note),
      .req_remote_step (req_remote_step),
      .rsp_sample_out  (rsp_sample_out)
   );

endmodule

/* rtl/pspm_checker.sv */
// Port-level checker for the sawtooth phase mixer and its bind statement.
`include "polyphonic_sawtooth_phase_mixer_unit_macros.svh"

module pspm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [pspm_pkg::SAMPLE_W-1:0] rsp_sample_out
);

   `PSPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_out), "rsp payload changed while stalled")
   `PSPM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while a tick is in progress")
   `PSPM_ASSERT_SAME(a_rsp_known, clock, reset, rsp_valid, !$isunknown(rsp_sample_out), "result sample is unknown while valid")

endmodule

bind polyphonic_sawtooth_phase_mixer_unit pspm_checker u_pspm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out)
);
